[design/lrupr_pkg.sv]
// ---------------------------------------------------------------------------
// lrupr_pkg
// Shared constants for the LRU page replacement block.
// ---------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

  localparam int NUM_FRAMES_DEF = 4;
  localparam int PAGE_BITS_DEF  = 20;

  // frames_in_use register
  localparam int              CFG_W     = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

  // fault counters
  localparam int CNT_W = 32;

endpackage : lrupr_pkg

`default_nettype wire

[design/lrupr_sat_cnt.sv]
// ---------------------------------------------------------------------------
// lrupr_sat_cnt
// Event counter that sticks at its all-ones value.
// ---------------------------------------------------------------------------
`default_nettype none

module lrupr_sat_cnt
  import lrupr_pkg::*;
#(
  parameter int WIDTH = CNT_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             inc,
  output logic [WIDTH-1:0]      count
);

  logic [WIDTH-1:0] count_next;

  always_comb begin
    count_next = count;
    if (inc && (count != '1)) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule : lrupr_sat_cnt

`default_nettype wire

[design/lru_page_replacement.sv]
// ---------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU frame set with hit/fault reporting.
// ---------------------------------------------------------------------------
// One page reference is taken per clock: busy stays low, and a reference
// transfers on any cycle with start high. Via the input and result
// registers its result appears on the result ports with done high for
// exactly one cycle; results come out in reference order and the
// receiver cannot stall them, so it must take every result on the cycle
// it is shown. The rate is one reference per cycle, set by a single pass
// of parallel tag compares, empty-frame and LRU selection and recency
// update between the input register and the result register. The counts
// on miss_count and replace_count include the reference being reported.
// Write frames_in_use (cfg_we/cfg_wdata) only while no reference is in
// flight; 0 acts as 1 and values above NUM_FRAMES act as NUM_FRAMES.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  localparam int IDX_W     = $clog2(NUM_FRAMES)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // reference command
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [PAGE_BITS-1:0] page_number,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  // result
  output logic                      done,
  output logic                      hit,
  output logic [IDX_W-1:0]          frame_index,
  output logic                      evicted_valid,
  output logic [PAGE_BITS-1:0]      evicted_page,
  output logic [CNT_W-1:0]          miss_count,
  output logic [CNT_W-1:0]          replace_count
);

  // registers
  logic [CFG_W-1:0]     frames_in_use;
  logic                 in_valid;
  logic [PAGE_BITS-1:0] in_page;
  logic [PAGE_BITS-1:0] frame_page [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid;
  logic [IDX_W-1:0]     rank [NUM_FRAMES];
  logic [IDX_W-1:0]     rank_next [NUM_FRAMES];

  // lookup
  logic [NUM_FRAMES-1:0] act;
  logic [NUM_FRAMES-1:0] match;
  logic [NUM_FRAMES-1:0] empty;
  logic [NUM_FRAMES-1:0] lru_oh;
  logic [NUM_FRAMES-1:0] sel_oh;
  logic                  hit_any;
  logic                  has_empty;
  logic                  evict;
  logic [IDX_W-1:0]      sel_idx;
  logic [IDX_W-1:0]      sel_rank;
  logic [PAGE_BITS-1:0]  victim_page;

  assign busy = 1'b0;

  always_comb begin
    logic older;
    for (int k = 0; k < NUM_FRAMES; k++) begin
      act[k]   = (k == 0) || (k < int'(frames_in_use));
      match[k] = act[k] && valid[k] && (frame_page[k] == in_page);
      empty[k] = act[k] && !valid[k];
    end

    // the LRU frame outranks every other active frame
    for (int k = 0; k < NUM_FRAMES; k++) begin
      older = act[k];
      for (int j = 0; j < NUM_FRAMES; j++) begin
        if ((j != k) && act[j] && (rank[j] >= rank[k])) begin
          older = 1'b0;
        end
      end
      lru_oh[k] = older;
    end

    hit_any   = |match;
    has_empty = |empty;
    evict     = !hit_any && !has_empty;

    // lowest set bit wins
    if (hit_any) begin
      sel_oh = match & (~match + 1'b1);
    end else if (has_empty) begin
      sel_oh = empty & (~empty + 1'b1);
    end else begin
      sel_oh = lru_oh;
    end

    sel_idx     = '0;
    sel_rank    = '0;
    victim_page = '0;
    for (int k = 0; k < NUM_FRAMES; k++) begin
      if (sel_oh[k]) begin
        sel_idx     = sel_idx | IDX_W'(k);
        sel_rank    = sel_rank | rank[k];
        victim_page = victim_page | frame_page[k];
      end
    end

    // move selected frame to the front, age the ones ahead of it
    for (int k = 0; k < NUM_FRAMES; k++) begin
      if (sel_oh[k]) begin
        rank_next[k] = '0;
      end else if (rank[k] < sel_rank) begin
        rank_next[k] = rank[k] + 1'b1;
      end else begin
        rank_next[k] = rank[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
      in_valid      <= 1'b0;
      valid         <= '0;
      done          <= 1'b0;
      for (int k = 0; k < NUM_FRAMES; k++) begin
        rank[k] <= IDX_W'(k);
      end
    end else begin
      if (cfg_we) begin
        frames_in_use <= cfg_wdata;
      end
      in_valid <= start && !busy;
      done     <= in_valid;
      if (in_valid) begin
        for (int k = 0; k < NUM_FRAMES; k++) begin
          rank[k] <= rank_next[k];
        end
        if (!hit_any) begin
          valid <= valid | sel_oh;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_page <= page_number;
    end
    if (in_valid && !hit_any) begin
      for (int k = 0; k < NUM_FRAMES; k++) begin
        if (sel_oh[k]) begin
          frame_page[k] <= in_page;
        end
      end
    end
    if (in_valid) begin
      hit           <= hit_any;
      frame_index   <= sel_idx;
      evicted_valid <= evict;
      evicted_page  <= evict ? victim_page : '0;
    end
  end

  lrupr_sat_cnt #(
    .WIDTH (CNT_W)
  ) u_miss_cnt (
    .clk   (clk),
    .rst   (rst),
    .inc   (in_valid && !hit_any),
    .count (miss_count)
  );

  lrupr_sat_cnt #(
    .WIDTH (CNT_W)
  ) u_replace_cnt (
    .clk   (clk),
    .rst   (rst),
    .inc   (in_valid && evict),
    .count (replace_count)
  );

`ifndef SYNTHESIS
  a_done_follows_start : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("reference transfer produced no result");

  a_sel_most_recent : assert property (@(posedge clk) disable iff (rst)
    in_valid |=> (rank[$past(sel_idx)] == '0))
    else $error("referenced frame not most recently used");

  a_evict_is_miss : assert property (@(posedge clk) disable iff (rst)
    (done && evicted_valid) |-> !hit)
    else $error("eviction reported on a hit");

  a_result_frame_valid : assert property (@(posedge clk) disable iff (rst)
    done |-> valid[frame_index])
    else $error("result frame not valid");

  a_miss_counted : assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (miss_count != '0))
    else $error("fault not counted");
`endif

endmodule : lru_page_replacement

`default_nettype wire
